// ===== src/bcdd_pkg.sv =====
// Shared widths, constants and types for the BCD display packer.
`default_nettype none
package bcdd_pkg;
    localparam int unsigned READING_W = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DIGITS    = 4;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned POS_W     = $clog2(DIGITS);
    localparam int unsigned WORD_W    = DIGITS * NIB_W;

    localparam logic [NIB_W-1:0] BLANK_NIB = 4'hF;

    // Values at or above this show only their leading four digits.
    localparam logic [READING_W-1:0] FIVE_DIGIT_MIN = 16'd10000;

    // Reciprocal constants for the divide-by-constant steps.
    localparam logic [15:0] RECIP_10_16  = 16'd52429;  // /10 with >>19, v < 65536
    localparam logic [13:0] RECIP_1000   = 14'd8389;   // /1000 with >>23, v < 10000
    localparam logic [5:0]  RECIP_100    = 6'd41;      // /100 with >>12, v < 1000
    localparam logic [7:0]  RECIP_10_7   = 8'd205;     // /10 with >>11, v < 100

    // Stall flag and scroll position travel with each item.
    typedef struct packed {
        logic             stall;
        logic [POS_W-1:0] pos;
    } t_side;
endpackage
`default_nettype wire

// ===== src/bcdd_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface bcdd_in_if;
    logic                              valid;
    logic                              ready;
    logic [bcdd_pkg::READING_W-1:0]    speed_reading;
    logic [bcdd_pkg::READING_W-1:0]    dwell_reading;
    logic                              show_dwell;

    modport source (output valid, output speed_reading, output dwell_reading,
                    output show_dwell, input ready);
    modport sink   (input valid, input speed_reading, input dwell_reading,
                    input show_dwell, output ready);
endinterface

interface bcdd_out_if;
    logic                           valid;
    logic                           ready;
    logic [bcdd_pkg::BYTE_W-1:0]    upper_byte;
    logic [bcdd_pkg::BYTE_W-1:0]    lower_byte;

    modport source (output valid, output upper_byte, output lower_byte, input ready);
    modport sink   (input valid, input upper_byte, input lower_byte, output ready);
endinterface
`default_nettype wire

// ===== src/bcd_display_with_stall_scroll_core.sv =====
// Top level: four-digit BCD display packer with a stall scroll pattern.
`default_nettype none
// Takes one update item per cycle unless o_item.ready holds the output
// (speed, dwell, panel switch) and returns one result item per input item:
// two bytes holding four BCD nibbles, most significant digit in the high
// nibble of o_item.upper_byte, 0xF for a blank digit. With nonzero speed the
// selected reading is shown in decimal, leading zeros blanked; readings of
// 10000 or more show their four leading digits. A zero speed advances the
// scroll position (mod 4, reset 0, advanced before use) and shows all blanks
// with a single 0 at that position, position 0 being the low nibble of
// o_item.lower_byte. Throughput is one item per cycle while o_item.ready
// lets the output move; each item passes through the five-register pipeline
// (capture, divide-by-ten fold, thousands, hundreds, digit assembly).
// Every stage has its own valid bit and loads whenever its successor frees up,
// so bubbles collapse while the output waits on o_item.ready.
module bcd_display_with_stall_scroll_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bcdd_in_if.sink    i_item,
    bcdd_out_if.source o_item
);
    import bcdd_pkg::*;

    // ---------------- stage valids and enables ----------------
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_o_v;
    logic en_a, en_b, en_c, en_d, en_o;

    assign en_o = !r_o_v || o_item.ready;
    assign en_d = !r_d_v || en_o;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;

    assign i_item.ready = en_a;

    logic accept;
    assign accept = i_item.valid && en_a;

    // ---------------- scroll position ----------------
    logic [POS_W-1:0] r_scroll;
    logic [POS_W-1:0] n_scroll;
    logic             in_stall;

    assign in_stall = (i_item.speed_reading == '0);
    // Advance before use, wrapping at the digit count.
    assign n_scroll = (r_scroll == POS_W'(DIGITS - 1)) ? '0 : r_scroll + 1'b1;

    // ---------------- stage A: capture ----------------
    logic [READING_W-1:0] r_a_val;
    t_side                r_a_side;

    // ---------------- stage B: fold five-digit values ----------------
    logic [31:0] b_prod;
    logic [13:0] b_val;
    logic [13:0] r_b_val;
    t_side       r_b_side;

    assign b_prod = 32'(r_a_val) * 32'(RECIP_10_16);
    assign b_val  = (r_a_val >= FIVE_DIGIT_MIN) ? 14'(b_prod[31:19]) : r_a_val[13:0];

    // ---------------- stage C: thousands digit ----------------
    logic [27:0]      c_prod;
    logic [NIB_W-1:0] r_c_d3;
    logic [13:0]      r_c_val;
    t_side            r_c_side;

    assign c_prod = 28'(r_b_val) * 28'(RECIP_1000);

    // ---------------- stage D: hundreds digit ----------------
    logic [13:0]      d_rem_full;
    logic [9:0]       d_rem;
    logic [15:0]      d_prod;
    logic [9:0]       r_d_rem;
    logic [NIB_W-1:0] r_d_d3, r_d_d2;
    t_side            r_d_side;

    assign d_rem_full = r_c_val - 14'(r_c_d3) * 14'd1000;
    assign d_rem      = d_rem_full[9:0];
    assign d_prod     = 16'(d_rem) * 16'(RECIP_100);

    // ---------------- stage O: tens, units, blanking ----------------
    logic [9:0]       o_rem_full;
    logic [6:0]       o_rem;
    logic [14:0]      o_prod;
    logic [NIB_W-1:0] o_d1, o_d0;
    logic [6:0]       o_units_full;
    logic             show3, show2, show1;
    logic [WORD_W-1:0] o_word_num, o_word_scroll, o_word;
    logic [WORD_W-1:0] r_o_word;

    assign o_rem_full   = r_d_rem - 10'(r_d_d2) * 10'd100;
    assign o_rem        = o_rem_full[6:0];
    assign o_prod       = 15'(o_rem) * 15'(RECIP_10_7);
    assign o_d1         = o_prod[14:11];
    assign o_units_full = o_rem - 7'(o_d1) * 7'd10;
    assign o_d0         = o_units_full[NIB_W-1:0];

    // Leading-zero blanking; the units digit always shows.
    assign show3 = (r_d_d3 != '0);
    assign show2 = show3 || (r_d_d2 != '0);
    assign show1 = show2 || (o_d1 != '0);

    assign o_word_num = {show3 ? r_d_d3 : BLANK_NIB,
                         show2 ? r_d_d2 : BLANK_NIB,
                         show1 ? o_d1   : BLANK_NIB,
                         o_d0};

    // All blanks except a zero nibble at the scroll position.
    always_comb begin
        o_word_scroll = '1;
        o_word_scroll[r_d_side.pos*NIB_W +: NIB_W] = '0;
    end

    assign o_word = r_d_side.stall ? o_word_scroll : o_word_num;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_o_v    <= 1'b0;
            r_scroll <= '0;
        end else begin
            if (en_a) r_a_v <= i_item.valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
            if (en_o) r_o_v <= r_d_v;
            if (accept && in_stall) r_scroll <= n_scroll;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_val        <= i_item.show_dwell ? i_item.dwell_reading
                                                : i_item.speed_reading;
            r_a_side.stall <= in_stall;
            r_a_side.pos   <= n_scroll;
        end
        if (en_b) begin
            r_b_val  <= b_val;
            r_b_side <= r_a_side;
        end
        if (en_c) begin
            r_c_d3   <= c_prod[26:23];
            r_c_val  <= r_b_val;
            r_c_side <= r_b_side;
        end
        if (en_d) begin
            r_d_rem  <= d_rem;
            r_d_d3   <= r_c_d3;
            r_d_d2   <= d_prod[15:12];
            r_d_side <= r_c_side;
        end
        if (en_o) begin
            r_o_word <= o_word;
        end
    end

    assign o_item.valid      = r_o_v;
    assign o_item.upper_byte = r_o_word[WORD_W-1:BYTE_W];
    assign o_item.lower_byte = r_o_word[BYTE_W-1:0];

`ifndef SYNTH
    // A stalled item moves the scroll position on by one.
    a_scroll_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_stall) |=> (r_scroll == $past(n_scroll)))
        else $error("scroll position did not advance on stalled item");

    // Running items leave the scroll position alone.
    a_scroll_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && in_stall) |=> $stable(r_scroll))
        else $error("scroll position changed without a stalled item");

    // Decimal digits stay in range after the reciprocal divides.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v |-> (r_d_d3 <= 4'd9) && (r_d_d2 <= 4'd9) && (o_d1 <= 4'd9) && (o_d0 <= 4'd9))
        else $error("BCD digit out of range");

    // A numeric result always shows its units digit.
    a_units_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_o && r_d_v && !r_d_side.stall) |=> (o_item.lower_byte[NIB_W-1:0] != BLANK_NIB))
        else $error("units digit blanked on a numeric result");
`endif
endmodule
`default_nettype wire

// ===== tb/bcd_display_with_stall_scroll_core_tb.sv =====
// Testbench for the BCD display packer: directed and random items checked against a predictor.
`default_nettype none
module bcd_display_with_stall_scroll_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bcdd_pkg::*;

    // One display update tick as offered on the input channel.
    typedef struct packed {
        logic [READING_W-1:0] speed;
        logic [READING_W-1:0] dwell;
        logic                 show_dwell;
    } t_tick;

    // The two display bytes of one result item.
    typedef struct packed {
        logic [BYTE_W-1:0] upper;
        logic [BYTE_W-1:0] lower;
    } t_disp;

    logic clk;
    logic rst_n;

    bcdd_in_if  in_ch ();
    bcdd_out_if out_ch ();

    bcd_display_with_stall_scroll_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (in_ch),
        .o_item  (out_ch)
    );

    // Items waiting for the driver, and display bytes owed by the block.
    t_tick pending_ticks[$];
    t_disp due_display[$];

    // Predictor state: scroll position, advanced on every stalled tick.
    logic [POS_W-1:0] scroll_pos;

    // Idle knobs, written only at the falling edge by the sequencer.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Long receiver hold-off: the sequencer toggles hold_req, the receiver counts.
    int unsigned hold_len;
    logic        hold_req;
    logic        hold_seen;
    int unsigned hold_left;

    // Bookkeeping.
    int unsigned errors;
    int unsigned checked;
    int unsigned n_stall;
    int unsigned n_five_digit;
    int unsigned n_dwell;
    int unsigned n_zero_shown;

    // ------------------------------------------------------------------
    // Predictor: display bytes for one accepted tick. A zero speed moves
    // the scroll position first and then draws the single 0 there; otherwise
    // the selected reading goes out in decimal, leading digits blanked.
    // ------------------------------------------------------------------
    function automatic t_disp predict_display(t_tick t);
        logic [WORD_W-1:0]    word;
        logic [READING_W-1:0] shown;
        int unsigned          v;
        int                   p;
        if (t.speed == '0) begin
            scroll_pos = scroll_pos + 1'b1;
            word = '1;
            word[scroll_pos*NIB_W +: NIB_W] = '0;
        end else begin
            shown = t.show_dwell ? t.dwell : t.speed;
            v = shown;
            // five-digit values lose their last digit
            if (shown >= FIVE_DIGIT_MIN) v = v / 10;
            for (p = 0; p < DIGITS; p++) begin
                // digit 0 always shows, so a zero reading is a lone 0
                if (p == 0 || v != 0) begin
                    word[p*NIB_W +: NIB_W] = NIB_W'(v % 10);
                    v = v / 10;
                end else begin
                    word[p*NIB_W +: NIB_W] = BLANK_NIB;
                end
            end
        end
        return t_disp'(word);
    endfunction

    // Reading with its digit count spread evenly, plus edges and full range.
    function automatic logic [READING_W-1:0] rand_reading();
        logic [READING_W-1:0] edges[10];
        edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                  16'd1000, 16'd9999, 16'd10000, 16'd65535};
        case ($urandom_range(0, 6))
            0: return READING_W'($urandom_range(0, 9));
            1: return READING_W'($urandom_range(10, 99));
            2: return READING_W'($urandom_range(100, 999));
            3: return READING_W'($urandom_range(1000, 9999));
            4: return READING_W'($urandom_range(10000, 65535));
            5: return edges[$urandom_range(0, 9)];
            default: return READING_W'($urandom);
        endcase
    endfunction

    // Queue random ticks; some come as runs of stalls so the scroll wraps.
    task automatic queue_random(int unsigned count);
        t_tick       t;
        int unsigned left;
        int unsigned run;
        left = count;
        while (left != 0) begin
            if ($urandom_range(99) < 12) begin
                run = $urandom_range(1, 6);
                if (run > left) run = left;
                repeat (run) begin
                    t.speed      = '0;
                    t.dwell      = READING_W'($urandom);
                    t.show_dwell = 1'($urandom);
                    pending_ticks.push_back(t);
                end
                left -= run;
            end else begin
                t.speed      = rand_reading();
                t.dwell      = rand_reading();
                t.show_dwell = 1'($urandom);
                pending_ticks.push_back(t);
                left--;
            end
        end
    endtask

    task automatic push_tick(logic [READING_W-1:0] sp, logic [READING_W-1:0] dw, logic sel);
        t_tick t;
        t.speed      = sp;
        t.dwell      = dw;
        t.show_dwell = sel;
        pending_ticks.push_back(t);
    endtask

    // Sequencer waits run on the falling edge, away from the driving edge.
    task automatic wait_ticks_taken();
        while (pending_ticks.size() != 0 || in_ch.valid) @(negedge clk);
    endtask

    task automatic wait_display_done();
        int unsigned guard;
        guard = 0;
        wait_ticks_taken();
        while (due_display.size() != 0 && guard < 20000) begin
            @(negedge clk);
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Far beyond the slowest legal run (about 750 items with idling and stalls
    // on each side, plus the hold-off).
    initial begin
        #4_000_000;
        $display("bcd_display_with_stall_scroll_core_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents the next queued tick when the channel is free,
    // idling at random; idle cycles carry junk payload.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_tick nxt;
        if (!rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.speed_reading <= '0;
            in_ch.dwell_reading <= '0;
            in_ch.show_dwell    <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ticks.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.speed_reading <= nxt.speed;
                in_ch.dwell_reading <= nxt.dwell;
                in_ch.show_dwell    <= nxt.show_dwell;
            end else begin
                in_ch.valid         <= 1'b0;
                in_ch.speed_reading <= READING_W'($urandom);
                in_ch.dwell_reading <= READING_W'($urandom);
                in_ch.show_dwell    <= 1'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off when requested.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= hold_len;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted tick, check every accepted result
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_tick t;
        t_disp got;
        t_disp want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                t.speed      = in_ch.speed_reading;
                t.dwell      = in_ch.dwell_reading;
                t.show_dwell = in_ch.show_dwell;
                if (t.speed == '0) n_stall++;
                else begin
                    if (t.show_dwell) n_dwell++;
                    if ((t.show_dwell ? t.dwell : t.speed) >= FIVE_DIGIT_MIN) n_five_digit++;
                    if ((t.show_dwell ? t.dwell : t.speed) == '0) n_zero_shown++;
                end
                due_display.push_back(predict_display(t));
            end
            if (out_ch.valid && out_ch.ready) begin
                got.upper = out_ch.upper_byte;
                got.lower = out_ch.lower_byte;
                if (due_display.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result upper=%02h lower=%02h",
                                 $realtime, got.upper, got.lower);
                end else begin
                    want = due_display.pop_front();
                    checked++;
                    if (got.upper !== want.upper || got.lower !== want.lower) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: result %0d expected %02h %02h, got %02h %02h",
                                     $realtime, checked, want.upper, want.lower,
                                     got.upper, got.lower);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    initial begin
        errors         = 0;
        checked        = 0;
        n_stall        = 0;
        n_five_digit   = 0;
        n_dwell        = 0;
        n_zero_shown   = 0;
        scroll_pos     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        hold_req       = 1'b0;
        // known values from time zero until the reset branches take over
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.speed_reading = '0;
        in_ch.dwell_reading = '0;
        in_ch.show_dwell    = 1'b0;
        out_ch.ready        = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: digit counts and their edges, the five-digit cut,
        // a zero reading, dwell selection, and stalls enough to wrap.
        push_tick(16'd1,     16'd0,     1'b0);
        push_tick(16'd9,     16'd0,     1'b0);
        push_tick(16'd10,    16'd0,     1'b0);
        push_tick(16'd99,    16'd0,     1'b0);
        push_tick(16'd100,   16'd0,     1'b0);
        push_tick(16'd999,   16'd0,     1'b0);
        push_tick(16'd1000,  16'd0,     1'b0);
        push_tick(16'd9999,  16'd0,     1'b0);
        push_tick(16'd10000, 16'd0,     1'b0);
        push_tick(16'd12345, 16'd0,     1'b0);
        push_tick(16'd65535, 16'd0,     1'b0);
        push_tick(16'd1,     16'd0,     1'b1);    // dwell of zero: lone 0
        push_tick(16'd65535, 16'd65535, 1'b1);
        push_tick(16'd5,     16'd10000, 1'b1);
        push_tick(16'd5,     16'd9999,  1'b1);
        push_tick(16'd0,     16'd0,     1'b0);    // first stall lands on position 1
        push_tick(16'd0,     16'd4321,  1'b1);    // stall pattern wins over dwell
        push_tick(16'd0,     16'd65535, 1'b0);
        push_tick(16'd0,     16'd0,     1'b1);    // wraps to position 0
        push_tick(16'd0,     16'd7,     1'b0);
        push_tick(16'd42,    16'd0,     1'b0);    // reading between stalls
        push_tick(16'd0,     16'd0,     1'b0);
        // sender stays quiet until every owed result is back
        wait_display_done();

        // No idling on either side.
        queue_random(150);
        wait_ticks_taken();

        // Receiver holds off long enough that the pipeline backs up into
        // the input while the sender keeps offering.
        hold_len = 300;
        hold_req = ~hold_req;
        queue_random(60);
        wait_display_done();

        // Sender idle most of the time.
        send_idle_pct  = 80;
        recv_stall_pct = 0;
        queue_random(170);
        wait_ticks_taken();

        // Receiver stalling most of the time.
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        queue_random(170);
        wait_ticks_taken();

        // Both sides idle now and then.
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        queue_random(170);
        wait_display_done();

        // Allow for the five-stage pipeline; anything that shows up now is extra.
        repeat (20) @(negedge clk);

        if (due_display.size() != 0) begin
            errors++;
            $display("%0d results never arrived", due_display.size());
        end

        $display("checked %0d results: %0d stalled ticks, %0d dwell readings,",
                 checked, n_stall, n_dwell);
        $display("  %0d five-digit values, %0d zero readings shown, %0d errors",
                 n_five_digit, n_zero_shown, errors);
        if (errors == 0) begin
            $display("bcd_display_with_stall_scroll_core_tb: done, clean");
        end else begin
            $display("bcd_display_with_stall_scroll_core_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/bcdd_pkg.sv
src/bcdd_if.sv
src/bcd_display_with_stall_scroll_core.sv
tb/bcd_display_with_stall_scroll_core_tb.sv
